@@ sv/assert_macros.svh @@
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/mvt_pkg.sv @@
// package: types and constants of the matrix vector transform unit
package mvt_pkg;

  localparam int FracBitsDefault = 16;

  localparam logic [1:0] CMD_WRITE    = 2'd0;
  localparam logic [1:0] CMD_COMPOSE  = 2'd1;
  localparam logic [1:0] CMD_XFORM    = 2'd2;
  localparam logic [1:0] CMD_IDENTITY = 2'd3;

  typedef struct packed {
    logic [1:0]         command;
    logic [3:0]         element_index;
    logic signed [31:0] element_value;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] vec_w;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_z;
    logic signed [31:0] res_w;
    logic               saturated;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic       load;      // capture command payload
    logic       write_stg; // write staging element
    logic       identity;  // reload identity
    logic       mul;       // form products for step
    logic       acc;       // reduce products of previous step
    logic [1:0] row;       // row of the step being multiplied
    logic       comp;      // step belongs to compose
    logic [1:0] col;       // column for compose step
    logic       commit;    // copy compose result into current matrix
    logic       emit;      // result ready
  } dp_ctrl_t;

endpackage

@@ sv/mvt_ctrl.sv @@
// controller: sequences transform and compose steps
module mvt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [1:0]      command,
  output logic            busy,
  output mvt_pkg::dp_ctrl_t ctrl
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RUN  = 3'd1;
  localparam logic [2:0] S_TAIL = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;

  logic [2:0] state, state_next;
  logic [3:0] step, step_next;   // row in [3:2], col in [1:0] for compose
  logic       comp, comp_next;
  logic       take;

  assign take = start && !busy;
  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    step_next  = step;
    comp_next  = comp;
    ctrl       = '0;
    ctrl.load      = take;
    ctrl.write_stg = take && command == mvt_pkg::CMD_WRITE;
    ctrl.identity  = take && command == mvt_pkg::CMD_IDENTITY;
    unique case (state)
      S_IDLE: begin
        if (take && (command == mvt_pkg::CMD_XFORM || command == mvt_pkg::CMD_COMPOSE)) begin
          state_next = S_RUN;
          step_next  = '0;
          comp_next  = (command == mvt_pkg::CMD_COMPOSE);
        end
      end
      S_RUN: begin
        ctrl.mul  = 1'b1;
        ctrl.comp = comp;
        ctrl.row  = comp ? step[3:2] : step[1:0];
        ctrl.col  = step[1:0];
        ctrl.acc  = (step != 4'd0);
        step_next = step + 4'd1;
        if ((comp && step == 4'd15) || (!comp && step == 4'd3)) state_next = S_TAIL;
      end
      S_TAIL: begin
        ctrl.acc  = 1'b1;
        ctrl.comp = comp;
        state_next = S_DONE;
      end
      S_DONE: begin
        ctrl.commit = comp;
        ctrl.emit   = !comp;
        state_next  = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      comp  <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      comp  <= comp_next;
    end
  end

endmodule

@@ sv/mvt_datapath.sv @@
// datapath: matrices, four multipliers, reduction and saturation
module mvt_datapath #(
  parameter int FRAC_BITS = mvt_pkg::FracBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  mvt_pkg::cmd_t      cmd,
  input  mvt_pkg::dp_ctrl_t  ctrl,
  output mvt_pkg::result_t   result,
  output logic               result_valid
);

  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  logic signed [31:0] cur [16];
  logic signed [31:0] stg [16];
  logic signed [31:0] nxt [16];
  logic signed [31:0] vec [4];
  logic signed [63:0] prod [4];
  logic [1:0]         prow;
  logic [1:0]         pcol;
  logic               pcomp;
  logic signed [65:0] sum;
  logic signed [65:0] shifted;
  logic signed [31:0] clip;
  logic               clipped;
  logic signed [31:0] res [4];
  logic               sat_acc;

  // exact sum of four products, floor shift, clip
  always_comb begin
    sum = 66'(prod[0]) + 66'(prod[1]) + 66'(prod[2]) + 66'(prod[3]);
    shifted = sum >>> FRAC_BITS;
    clipped = 1'b0;
    if (shifted > 66'sd2147483647) begin
      clip = 32'h7fffffff; clipped = 1'b1;
    end else if (shifted < -66'sd2147483648) begin
      clip = 32'h80000000; clipped = 1'b1;
    end else begin
      clip = shifted[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        cur[i] <= (i % 5 == 0) ? ONE : 32'sd0;
        stg[i] <= 32'sd0;
      end
      result_valid <= 1'b0;
    end else begin
      result_valid <= ctrl.emit;
      if (ctrl.write_stg) stg[cmd.element_index] <= cmd.element_value;
      if (ctrl.identity)
        for (int i = 0; i < 16; i++) cur[i] <= (i % 5 == 0) ? ONE : 32'sd0;
      if (ctrl.commit)
        for (int i = 0; i < 16; i++) cur[i] <= nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      vec[0] <= cmd.vec_x; vec[1] <= cmd.vec_y;
      vec[2] <= cmd.vec_z; vec[3] <= cmd.vec_w;
      sat_acc <= 1'b0;
    end
    if (ctrl.mul) begin
      for (int k = 0; k < 4; k++)
        prod[k] <= 64'(cur[{ctrl.row, 2'(k)}]) *
                   64'(ctrl.comp ? stg[{2'(k), ctrl.col}] : vec[k]);
      prow  <= ctrl.row;
      pcol  <= ctrl.col;
      pcomp <= ctrl.comp;
    end
    if (ctrl.acc) begin
      if (pcomp) nxt[{prow, pcol}] <= clip;
      else begin
        res[prow] <= clip;
        sat_acc   <= sat_acc | clipped;
      end
    end
  end

  assign result.res_x     = res[0];
  assign result.res_y     = res[1];
  assign result.res_z     = res[2];
  assign result.res_w     = res[3];
  assign result.saturated = sat_acc;

endmodule

@@ sv/matrix_vector_transform_unit.sv @@
// top level: 4x4 homogeneous matrix transform engine
// A transaction is taken when start is high and busy is low. Write staging and
// set identity take effect at the accepting clock edge and leave busy low. A
// transform keeps busy high through 4 row steps on four 32x32 multipliers, one
// reduction step and one result step; the result shows on result for exactly one
// cycle with done high, in the first cycle with busy low again, and cannot be
// stalled. Compose keeps busy high through 16 element steps on the same
// multipliers, one reduction step and one commit step, and returns nothing.
// All of these steps share the four-multiplier datapath.
module matrix_vector_transform_unit #(
  parameter int FRAC_BITS = mvt_pkg::FracBitsDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  mvt_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done,
  output mvt_pkg::result_t result
);

`include "assert_macros.svh"

  mvt_pkg::dp_ctrl_t ctrl;

  // sequencing of row and element steps
  mvt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (cmd.command),
    .busy    (busy),
    .ctrl    (ctrl)
  );

  // matrices, multipliers and saturation
  mvt_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .ctrl         (ctrl),
    .result       (result),
    .result_valid (done)
  );

  // a result only appears once the controller is back to idle
  `ASSERT_IMPL(a_done_idle, clk, rst, done, !busy, "done while busy")
  // the result step of a transform is always followed by a result
  `ASSERT_NEXT(a_emit_done, clk, rst, ctrl.emit, done, "emit lost")
  // compose commit and result emit are exclusive
  `ASSERT_IMPL(a_commit_emit, clk, rst, ctrl.commit, !ctrl.emit, "commit with emit")

endmodule

@@ verif/tb_matrix_vector_transform_unit.sv @@
// testbench for the 4x4 homogeneous matrix transform unit
module tb_matrix_vector_transform_unit;

  localparam int FRAC = mvt_pkg::FracBitsDefault;
  localparam int IDLE_LIMIT = 2000;
  localparam logic signed [31:0] ONE = 32'sd1 << FRAC;
  localparam logic signed [31:0] MAXV = 32'sh7fffffff;
  localparam logic signed [31:0] MINV = 32'sh80000000;

  logic             clk;
  logic             rst;
  logic             start;
  mvt_pkg::cmd_t    cmd;
  logic             busy;
  logic             done;
  mvt_pkg::result_t result;

  matrix_vector_transform_unit u_top (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done),
    .result(result)
  );

  // predictor state: current and staging matrices, row-major
  logic signed [31:0] cur_mat [16];
  logic signed [31:0] stg_mat [16];
  mvt_pkg::result_t   pending_results [$];
  int                 fail_count = 0;
  int                 idle_cycles;
  bit                 stim_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // exact dot product, floor-scaled by FRAC, clipped to 32 bits
  function automatic logic signed [31:0] dot_clip(input logic signed [31:0] a [4],
                                                  input logic signed [31:0] b [4],
                                                  inout bit clipped);
    logic signed [95:0] acc;
    logic signed [95:0] scaled;
    acc = '0;
    for (int k = 0; k < 4; k++) acc += 96'(a[k]) * 96'(b[k]);
    scaled = acc >>> FRAC;
    if (scaled > 96'(MAXV)) begin
      clipped = 1'b1;
      return MAXV;
    end
    if (scaled < 96'(MINV)) begin
      clipped = 1'b1;
      return MINV;
    end
    return scaled[31:0];
  endfunction

  task automatic load_identity();
    for (int i = 0; i < 16; i++) cur_mat[i] = (i % 5 == 0) ? ONE : '0;
  endtask

  // advance the matrices for one accepted transaction, queue any result
  task automatic predict_transaction(input mvt_pkg::cmd_t c);
    logic signed [31:0] a [4];
    logic signed [31:0] b [4];
    logic signed [31:0] nxt [16];
    logic signed [31:0] comp [4];
    bit clipped;
    mvt_pkg::result_t r;
    clipped = 1'b0;
    case (c.command)
      mvt_pkg::CMD_WRITE: begin
        stg_mat[c.element_index] = c.element_value;
      end
      mvt_pkg::CMD_COMPOSE: begin
        for (int row = 0; row < 4; row++)
          for (int col = 0; col < 4; col++) begin
            for (int k = 0; k < 4; k++) begin
              a[k] = cur_mat[row*4+k];
              b[k] = stg_mat[k*4+col];
            end
            nxt[row*4+col] = dot_clip(a, b, clipped);
          end
        cur_mat = nxt;
      end
      mvt_pkg::CMD_XFORM: begin
        b = '{c.vec_x, c.vec_y, c.vec_z, c.vec_w};
        for (int i = 0; i < 4; i++) begin
          for (int k = 0; k < 4; k++) a[k] = cur_mat[i*4+k];
          comp[i] = dot_clip(a, b, clipped);
        end
        r.res_x = comp[0];
        r.res_y = comp[1];
        r.res_z = comp[2];
        r.res_w = comp[3];
        r.saturated = clipped;
        pending_results.push_back(r);
      end
      default: load_identity();
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h actual %h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // result checking and the watchdog, both at the rising edge
  always @(posedge clk) begin
    mvt_pkg::result_t e;
    if (rst) idle_cycles <= 0;
    else begin
      if (start && !busy) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (done) begin
        if (pending_results.size() == 0) begin
          $error("unexpected transform result %p", result);
          fail_count++;
        end else begin
          e = pending_results.pop_front();
          check_field("res_x", e.res_x, result.res_x);
          check_field("res_y", e.res_y, result.res_y);
          check_field("res_z", e.res_z, result.res_z);
          check_field("res_w", e.res_w, result.res_w);
          check_field("saturated", 32'(e.saturated), 32'(result.saturated));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && !stim_done && idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog timeout");
      $display("Test completed with failures");
      $finish;
    end
  end

  // directed table; typed-in expectation only where obvious
  typedef struct {
    mvt_pkg::cmd_t    c;
    bit               typed;
    mvt_pkg::result_t exp_r;
  } dir_row_t;

  dir_row_t dir_rows [$];

  function automatic mvt_pkg::cmd_t make_cmd(input logic [1:0] op, input logic [3:0] idx,
                                             input logic [31:0] val, input logic [31:0] x,
                                             input logic [31:0] y, input logic [31:0] z,
                                             input logic [31:0] w);
    mvt_pkg::cmd_t c;
    c.command = op;
    c.element_index = idx;
    c.element_value = val;
    c.vec_x = x;
    c.vec_y = y;
    c.vec_z = z;
    c.vec_w = w;
    return c;
  endfunction

  function automatic mvt_pkg::result_t make_res(input logic [31:0] x, input logic [31:0] y,
                                                input logic [31:0] z, input logic [31:0] w,
                                                input logic s);
    mvt_pkg::result_t r;
    r.res_x = x;
    r.res_y = y;
    r.res_z = z;
    r.res_w = w;
    r.saturated = s;
    return r;
  endfunction

  function automatic mvt_pkg::cmd_t rand_cmd(input logic [1:0] op);
    return make_cmd(op, 4'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  // random Q16.16 value, mostly moderate so composed matrices stay meaningful
  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? MAXV : MINV;
      2: return $urandom_range(0, 1) ? ONE : -ONE;
      default: return 32'($signed(17'($urandom)));
    endcase
  endfunction

  // drive one transaction at the falling edge and wait for its acceptance
  task automatic send(input mvt_pkg::cmd_t c);
    @(negedge clk);
    start <= 1'b1;
    cmd   <= c;
    while (busy) @(negedge clk);
    @(posedge clk);
    predict_transaction(c);
  endtask

  task automatic release_start();
    @(negedge clk);
    start <= 1'b0;
    cmd   <= rand_cmd(mvt_pkg::CMD_IDENTITY);
  endtask

  task automatic gap(input bit allowed);
    int n;
    if (allowed && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 15);
      release_start();
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  initial begin
    mvt_pkg::cmd_t c;
    int n_items;
    stim_done = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    for (int i = 0; i < 16; i++) stg_mat[i] = '0;
    load_identity();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // identity passes vectors through unchanged, including the extremes
    dir_rows.push_back('{make_cmd(mvt_pkg::CMD_XFORM, 4'd0, 0, MAXV, MINV, 0, ONE), 1'b1,
                         make_res(MAXV, MINV, 0, ONE, 1'b0)});
    dir_rows.push_back('{make_cmd(mvt_pkg::CMD_XFORM, 4'hf, MAXV, -1, 1, MINV, MAXV), 1'b1,
                         make_res(-1, 1, MINV, MAXV, 1'b0)});
    // staging is zero after reset, so compose zeroes the current matrix
    dir_rows.push_back('{make_cmd(mvt_pkg::CMD_COMPOSE, 4'd0, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{make_cmd(mvt_pkg::CMD_XFORM, 4'd0, 0, MAXV, MAXV, MAXV, MAXV), 1'b1,
                         make_res(0, 0, 0, 0, 1'b0)});
    dir_rows.push_back('{make_cmd(mvt_pkg::CMD_IDENTITY, 4'hf, -1, -1, -1, -1, -1), 1'b0, '0});
    // fill staging with extremes, compose it onto identity, then transform; the last transform saturates
    for (int i = 0; i < 16; i++)
      dir_rows.push_back('{make_cmd(mvt_pkg::CMD_WRITE, 4'(i), (i % 2) ? MINV : MAXV,
                                    0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{make_cmd(mvt_pkg::CMD_COMPOSE, 4'd0, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{make_cmd(mvt_pkg::CMD_XFORM, 4'd0, 0, MAXV, MAXV, MAXV, MAXV),
                         1'b0, '0});
    dir_rows.push_back('{make_cmd(mvt_pkg::CMD_XFORM, 4'd0, 0, -ONE, 1, MINV, 0), 1'b0, '0});
    dir_rows.push_back('{make_cmd(mvt_pkg::CMD_IDENTITY, 4'd0, 0, 0, 0, 0, 0), 1'b0, '0});

    foreach (dir_rows[i]) begin
      send(dir_rows[i].c);
      if (dir_rows[i].typed) pending_results[$] = dir_rows[i].exp_r;
      gap(1'b1);
    end
    release_start();
    drain();

    // random part: random commands, identity reloads, writes followed by compose or transform
    n_items = 0;
    while (n_items < 500) begin
      if ($urandom_range(0, 3) == 0) begin
        c = rand_cmd(2'($urandom));
        if (c.command == mvt_pkg::CMD_WRITE) c.element_value = rand_val();
      end else begin
        if ($urandom_range(0, 2) == 0) c = rand_cmd(mvt_pkg::CMD_IDENTITY);
        else begin
          c = rand_cmd(mvt_pkg::CMD_WRITE);
          c.element_value = rand_val();
          send(c);
          n_items++;
          gap(n_items < 420);
          c = rand_cmd($urandom_range(0, 3) == 0 ? mvt_pkg::CMD_COMPOSE
                                                 : mvt_pkg::CMD_XFORM);
        end
      end
      if (c.command == mvt_pkg::CMD_XFORM && $urandom_range(0, 1))
        {c.vec_x, c.vec_y, c.vec_z, c.vec_w} = {rand_val(), rand_val(), rand_val(), rand_val()};
      send(c);
      n_items++;
      gap(n_items < 420);
      // hold off until all results are back, once in a while
      if (n_items % 97 == 0) begin
        release_start();
        drain();
      end
    end
    release_start();
    stim_done = 1'b1;
    drain();

    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  // results still waiting at the end also count as failures
  always @(posedge clk) begin
    if (stim_done && pending_results.size() != 0 && idle_cycles >= IDLE_LIMIT) begin
      $display("expected results never arrived");
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
